@@ sv/pwolt_pkg.sv @@
`timescale 1ns / 1ps

package pwolt_pkg;

    // Default timer width; every duration register is TIMER_BITS wide, which defaults to this.
    localparam int TIMER_BITS_DEF = 17;

    // Bits per byte, and the width of the bit counter across both bytes.
    localparam int BITS_PER_BYTE = 8;
    localparam int WORD_BITS     = 2 * BITS_PER_BYTE;
    localparam int BIT_IDX_BITS  = $clog2(WORD_BITS);

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_LOW = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SHORT     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAP_HIGH  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_TAIL_HIGH = 3'd4;

    // Reset values of the duration registers, in ticks
    localparam int RST_START_LOW = 5000;
    localparam int RST_LONG      = 600;
    localparam int RST_SHORT     = 200;
    localparam int RST_GAP_HIGH  = 2000;
    localparam int RST_TAIL_HIGH = 100000;

    // Output word layout
    localparam int OUT_BYTES = 1;

    // Item kind after classification
    typedef enum logic
    {
        OP_TICK = 1'b0,
        OP_SEND = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                  op;
        logic [WORD_BITS-1:0] word;
    } item_t;

endpackage

@@ sv/pulse_width_one_line_tx.sv @@
`timescale 1ns / 1ps

// Single-wire pulse-width command transmitter. A send word (tuser = 1) loads
// a 16-bit command and starts a frame on a line that idles high; tick words
// (tuser = 0) advance time by one unit. Each byte goes out high byte first:
// the line is low for start_low_ticks, then eight bits LSB first, a 1 as
// long high + short low and a 0 as short high + long low. Between the two
// bytes the line is held high for gap_high_ticks, after the second byte for
// tail_high_ticks, and then the block is idle. A send while busy is ignored.
// Every input word yields exactly one result word: line level, busy,
// accepted and done flags. Throughput is one word per clock unless the
// result side stalls; a word passes the front queue, then the output
// register. The queue (two entries) and the output register let the two
// stream sides stall independently. Durations must be written through the
// cfg port only while no frame is in progress, which the block does not enforce.
module pulse_width_one_line_tx
#(
    parameter int TIMER_BITS = pwolt_pkg::TIMER_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Duration registers, in ticks: 0 start low, 1 long, 2 short,
    // 3 gap high, 4 tail high
    input  logic                                cfg_we,
    input  logic [pwolt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [TIMER_BITS-1:0]               cfg_data,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pwolt_pkg::WORD_BITS-1:0]     s_tdata,   // [15:0] word
    input  logic                                s_tuser,   // [0] cmd: 0 tick, 1 send
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] line_level, [1] busy_res, [2] accepted, [3] done_res, [7:4] zero
    output logic [8*pwolt_pkg::OUT_BYTES-1:0]   m_tdata
);

    logic             q_valid;
    logic             q_pop;
    pwolt_pkg::item_t q_item;

    // Front: accept and classify, queue for the sequencer
    pwolt_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    // Back: step the frame sequencer and register each result
    pwolt_back
    #(
        .TIMER_BITS (TIMER_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ sv/pwolt_front.sv @@
`timescale 1ns / 1ps

// Accept input words, classify them as tick or send, and hold them in a
// two-entry queue for the sequencer.
module pwolt_front
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [pwolt_pkg::WORD_BITS-1:0]        s_tdata,
    input  logic                                   s_tuser,
    output logic                                   q_valid,
    input  logic                                   q_pop,
    output pwolt_pkg::item_t                       q_item
);

    pwolt_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    pwolt_pkg::item_t in_item;

    always_comb
    begin
        in_item.op   = s_tuser ? pwolt_pkg::OP_SEND : pwolt_pkg::OP_TICK;
        in_item.word = s_tdata;
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ sv/pwolt_back.sv @@
`timescale 1ns / 1ps

// Line sequencer: hold the duration registers, step the frame one item at a
// time and register the result word.
module pwolt_back
#(
    parameter int TIMER_BITS = pwolt_pkg::TIMER_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pwolt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [TIMER_BITS-1:0]                cfg_data,
    input  logic                                 q_valid,
    output logic                                 q_pop,
    input  pwolt_pkg::item_t                     q_item,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [8*pwolt_pkg::OUT_BYTES-1:0]    m_tdata
);

    typedef enum logic [2:0]
    {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_BITHI = 3'd2,
        PH_BITLO = 3'd3,
        PH_GAP   = 3'd4,
        PH_TAIL  = 3'd5
    } phase_t;

    localparam int BIB = pwolt_pkg::BIT_IDX_BITS;

    logic [TIMER_BITS-1:0] start_low_reg;
    logic [TIMER_BITS-1:0] long_reg;
    logic [TIMER_BITS-1:0] short_reg;
    logic [TIMER_BITS-1:0] gap_high_reg;
    logic [TIMER_BITS-1:0] tail_high_reg;

    phase_t                          phase_reg;
    phase_t                          phase_next;
    logic [pwolt_pkg::WORD_BITS-1:0] shift_reg;
    logic [pwolt_pkg::WORD_BITS-1:0] shift_next;
    logic [BIB-1:0]                  bit_idx_reg;
    logic [BIB-1:0]                  bit_idx_next;
    logic [BIB-1:0]                  bit_idx_inc;
    logic [TIMER_BITS-1:0]           time_reg;
    logic [TIMER_BITS-1:0]           time_next;
    logic                            line_reg;
    logic                            line_next;

    logic                            out_valid_reg;
    logic [8*pwolt_pkg::OUT_BYTES-1:0] out_data_reg;
    logic [8*pwolt_pkg::OUT_BYTES-1:0] out_data_next;

    logic cur_bit;
    logic inc_bit;
    logic accepted;
    logic done;

    // Bit numbers 0..7 are the high byte, LSB first; flipping the top index
    // bit maps a bit number onto its position in the word.
    assign cur_bit = shift_reg[{~bit_idx_reg[BIB-1], bit_idx_reg[BIB-2:0]}];
    assign inc_bit = shift_reg[{~bit_idx_inc[BIB-1], bit_idx_inc[BIB-2:0]}];
    assign bit_idx_inc = bit_idx_reg + {{(BIB-1){1'b0}}, 1'b1};

    assign q_pop    = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        shift_next   = shift_reg;
        bit_idx_next = bit_idx_reg;
        time_next    = time_reg;
        line_next    = line_reg;
        accepted     = 1'b0;
        done         = 1'b0;

        if (q_pop)
        begin
            if (q_item.op == pwolt_pkg::OP_SEND)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    shift_next   = q_item.word;
                    bit_idx_next = '0;
                    phase_next   = PH_START;
                    time_next    = start_low_reg;
                    line_next    = 1'b0;
                    accepted     = 1'b1;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (time_reg <= TIMER_BITS'(1))
                begin
                    unique case (phase_reg)
                        PH_START:
                        begin
                            phase_next = PH_BITHI;
                            time_next  = cur_bit ? long_reg : short_reg;
                            line_next  = 1'b1;
                        end
                        PH_BITHI:
                        begin
                            phase_next = PH_BITLO;
                            time_next  = cur_bit ? short_reg : long_reg;
                            line_next  = 1'b0;
                        end
                        PH_BITLO:
                        begin
                            bit_idx_next = bit_idx_inc;
                            line_next    = 1'b1;
                            if (bit_idx_inc == BIB'(pwolt_pkg::BITS_PER_BYTE))
                            begin
                                phase_next = PH_GAP;
                                time_next  = gap_high_reg;
                            end
                            else if (bit_idx_inc == '0)
                            begin
                                phase_next = PH_TAIL;
                                time_next  = tail_high_reg;
                            end
                            else
                            begin
                                phase_next = PH_BITHI;
                                time_next  = inc_bit ? long_reg : short_reg;
                            end
                        end
                        PH_GAP:
                        begin
                            phase_next = PH_START;
                            time_next  = start_low_reg;
                            line_next  = 1'b0;
                        end
                        PH_TAIL:
                        begin
                            phase_next   = PH_IDLE;
                            time_next    = '0;
                            line_next    = 1'b1;
                            bit_idx_next = '0;
                            done         = 1'b1;
                        end
                        default:
                        begin
                            phase_next   = PH_IDLE;
                            time_next    = '0;
                            line_next    = 1'b1;
                            bit_idx_next = '0;
                        end
                    endcase
                end
                else
                begin
                    time_next = time_reg - TIMER_BITS'(1);
                end
            end
        end

        out_data_next = '0;
        out_data_next[0] = line_next;
        out_data_next[1] = (phase_next != PH_IDLE);
        out_data_next[2] = accepted;
        out_data_next[3] = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_low_reg <= TIMER_BITS'(pwolt_pkg::RST_START_LOW);
            long_reg      <= TIMER_BITS'(pwolt_pkg::RST_LONG);
            short_reg     <= TIMER_BITS'(pwolt_pkg::RST_SHORT);
            gap_high_reg  <= TIMER_BITS'(pwolt_pkg::RST_GAP_HIGH);
            tail_high_reg <= TIMER_BITS'(pwolt_pkg::RST_TAIL_HIGH);
            phase_reg     <= PH_IDLE;
            shift_reg     <= '0;
            bit_idx_reg   <= '0;
            time_reg      <= '0;
            line_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pwolt_pkg::REG_START_LOW: start_low_reg <= cfg_data;
                    pwolt_pkg::REG_LONG:      long_reg      <= cfg_data;
                    pwolt_pkg::REG_SHORT:     short_reg     <= cfg_data;
                    pwolt_pkg::REG_GAP_HIGH:  gap_high_reg  <= cfg_data;
                    pwolt_pkg::REG_TAIL_HIGH: tail_high_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            phase_reg   <= phase_next;
            shift_reg   <= shift_next;
            bit_idx_reg <= bit_idx_next;
            time_reg    <= time_next;
            line_reg    <= line_next;
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= out_data_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ sv/pwolt_checker.sv @@
`timescale 1ns / 1ps

module pwolt_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A word that starts a frame reports the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[1])
        else $error("accepted without busy");

    // The frame end leaves the block idle with the line high.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> !m_tdata[1] && m_tdata[0] && !m_tdata[2])
        else $error("done with busy or line low");

    // Idle line is always high.
    a_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[1] |-> m_tdata[0])
        else $error("line low while idle");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind pulse_width_one_line_tx pwolt_checker u_pwolt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
